// ===== src/fwd_pkg.sv =====
package fwd_pkg;

  localparam int DEPTH = 16;

  localparam int CMD_W = 2;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int POS_W = 4;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  // Broadcast to every cell for one accepted word; the enables are already
  // qualified by the input handshake.
  typedef struct packed {
    logic                    enq;
    logic                    deq;
    logic                    del;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== src/fwd_if.sv =====
interface fwd_in_if;
  logic                             valid;
  logic                             ready;
  logic [fwd_pkg::CMD_W-1:0]        command;
  logic signed [fwd_pkg::VAL_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface fwd_out_if;
  logic                             valid;
  logic                             ready;
  logic [fwd_pkg::ST_W-1:0]         status;
  logic signed [fwd_pkg::VAL_W-1:0] data;
  logic [fwd_pkg::POS_W-1:0]        position;

  modport source (output valid, output status, output data, output position, input ready);
  modport sink   (input valid, input status, input data, input position, output ready);
endinterface

// ===== src/fwd_cell.sv =====
module fwd_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fwd_pkg::cell_ctrl_t              ctrl,
  input  logic                             left_valid,
  input  logic                             right_valid,
  input  logic signed [fwd_pkg::VAL_W-1:0] right_data,
  input  logic                             hit_in,
  output logic                             hit_out,
  output logic                             first,
  output logic                             valid,
  output logic signed [fwd_pkg::VAL_W-1:0] data
);

  logic                             valid_r, valid_nxt;
  logic signed [fwd_pkg::VAL_W-1:0] data_r, data_nxt;
  logic                             match;
  logic                             shift;
  logic                             load;

  assign match   = valid_r && (data_r == ctrl.value);
  assign hit_out = hit_in | match;
  assign first   = match & ~hit_in;

  // Dequeue shifts every cell; delete, those at or behind the first match.
  assign shift = ctrl.deq | (ctrl.del & hit_out);
  assign load  = ctrl.enq & ~valid_r & left_valid;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (shift) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = ctrl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

// ===== src/fifo_with_delete_by_value.sv =====
// Bounded queue of DEPTH signed 32-bit entries that also removes an entry by
// value. Each input word carries a command (enqueue, dequeue or delete first
// match) and a value, and produces exactly one result word with a status,
// the dequeued data and the position of a deleted entry counted from the
// head. The queue is a row of DEPTH cells, cell 0 holding the head; every
// cell compares its entry with the value in parallel and a hit flag ripples
// from the head towards the tail, so the first match and everything behind
// it shift one place forward in the same cycle. One word is taken every
// clock cycle while the result channel does not stall; the result is
// registered, and the path that limits the clock is the hit ripple
// through the DEPTH cells. A new word is accepted while a result waits,
// provided that result is taken in the same cycle.
module fifo_with_delete_by_value #(
  parameter int DEPTH = fwd_pkg::DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  fwd_in_if.sink           in_ch,
  fwd_out_if.source        out_ch
);

  fwd_pkg::cell_ctrl_t              ctrl;
  logic                             accept;
  logic                             full;
  logic                             empty;
  logic                             found;

  logic [DEPTH-1:0]                 cell_valid;
  logic signed [fwd_pkg::VAL_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]                 cell_first;
  logic [DEPTH:0]                   hit_chain;
  logic [fwd_pkg::POS_W-1:0]        first_pos;

  logic                             out_valid_r, out_valid_nxt;
  logic [fwd_pkg::ST_W-1:0]         status_r, status_nxt;
  logic signed [fwd_pkg::VAL_W-1:0] data_r, data_nxt;
  logic [fwd_pkg::POS_W-1:0]        position_r, position_nxt;

  // The result register frees up when its word is taken, so the input may
  // be accepted in that same cycle.
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;

  // Command decode. Code three matches none of the enables and so leaves
  // the queue untouched.
  assign ctrl.enq   = accept && (in_ch.command == fwd_pkg::CMD_ENQUEUE);
  assign ctrl.deq   = accept && (in_ch.command == fwd_pkg::CMD_DEQUEUE) && !empty;
  assign ctrl.del   = accept && (in_ch.command == fwd_pkg::CMD_DELETE);
  assign ctrl.value = in_ch.value;

  // Entries are packed from the head, so the end cells tell the fill state.
  assign full  = cell_valid[DEPTH-1];
  assign empty = ~cell_valid[0];

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                             left_valid;
    logic                             right_valid;
    logic signed [fwd_pkg::VAL_W-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_data  = '0;
    end else begin : g_inner
      assign right_valid = cell_valid[i+1];
      assign right_data  = cell_data[i+1];
    end

    fwd_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_valid  (left_valid),
      .right_valid (right_valid),
      .right_data  (right_data),
      .hit_in      (hit_chain[i]),
      .hit_out     (hit_chain[i+1]),
      .first       (cell_first[i]),
      .valid       (cell_valid[i]),
      .data        (cell_data[i])
    );
  end

  // Any hit at all reaches the end of the chain.
  assign found = hit_chain[DEPTH];

  // At most one cell flags the first match, so its index is an OR of the
  // indices gated by those flags. Only the low four bits are reported.
  always_comb begin
    first_pos = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (cell_first[k]) begin
        first_pos = first_pos | fwd_pkg::POS_W'(k);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    position_nxt  = position_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = fwd_pkg::ST_OK;
      data_nxt      = '0;
      position_nxt  = '0;
      case (in_ch.command)
        fwd_pkg::CMD_ENQUEUE: begin
          if (full) begin
            status_nxt = fwd_pkg::ST_FULL;
          end
        end
        fwd_pkg::CMD_DEQUEUE: begin
          if (empty) begin
            status_nxt = fwd_pkg::ST_EMPTY;
          end else begin
            data_nxt = cell_data[0];
          end
        end
        fwd_pkg::CMD_DELETE: begin
          if (found) begin
            position_nxt = first_pos;
          end else begin
            status_nxt = fwd_pkg::ST_NOTFOUND;
          end
        end
        default: begin
          status_nxt = fwd_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    data_r     <= data_nxt;
    position_r <= position_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = status_r;
  assign out_ch.data     = data_r;
  assign out_ch.position = position_r;

endmodule
